FILE: src/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// shared constants and types for the depth-first topological sort block
// ----------------------------------------------------------------------------
package dts_pkg;
    localparam int MaxVertices = 32;
    localparam int VW          = 6;              // vertex number width
    localparam int AW          = $clog2(MaxVertices);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        COL_WHITE = 2'd0,
        COL_GRAY  = 2'd1,
        COL_BLACK = 2'd2
    } t_colour;
endpackage

FILE: src/dts_ram.sv
// ----------------------------------------------------------------------------
// dts_ram
// generic synchronous ram with one write port and one read port, registered read
// ----------------------------------------------------------------------------
module dts_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/dfs_topological_sort.sv
// ----------------------------------------------------------------------------
// dfs_topological_sort
// adjacency matrix loader and depth-first topological sort with cycle check
// ----------------------------------------------------------------------------
// Edge loads read the adjacency row, then write it back with the new
// bit. A clear sweeps every adjacency row to zero, during which no
// transaction is accepted; reset performs the same sweep. A run walks the
// graph with the stack top held in registers: each step reads a row and
// scans it for the next neighbor, a finished vertex is popped through a
// stack read, each root candidate is tried in turn, and the results are
// output at one per cycle while the receiver is ready. Colors are in
// flip-flops and reset at the start of every run. Stack and finish order
// are rams that are read only where written.
module dfs_topological_sort (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_edge_from,
    input  logic [5:0]  i_edge_to,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [5:0]  o_value,
    output logic        o_last
);
    localparam int N  = dts_pkg::MaxVertices;
    localparam int AW = dts_pkg::AW;
    localparam int VW = dts_pkg::VW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROOT, S_READ, S_STEP, S_STAT, S_OUTRD, S_OUT, S_ADD
    } t_state;

    t_state          r_state;
    logic [VW-1:0]   r_count;
    logic [AW-1:0]   r_clr;
    logic [VW-1:0]   r_n;
    logic [VW-1:0]   r_root;
    logic [VW-1:0]   r_depth;
    logic [VW-1:0]   r_fin;
    logic [VW-1:0]   r_top_v;
    logic [VW-1:0]   r_top_next;
    logic [1:0]      r_col [N];
    logic [AW-1:0]   r_efrom;
    logic [VW-1:0]   r_eto;
    logic            r_ovalid;
    logic            r_okind;
    logic [VW-1:0]   r_ovalue;
    logic            r_olast;

    // ram ports
    logic            adj_we;
    logic [AW-1:0]   adj_waddr, adj_raddr;
    logic [N-1:0]    adj_wdata, adj_rdata;
    logic            stk_we;
    logic [AW-1:0]   stk_waddr, stk_raddr;
    logic [2*VW-1:0] stk_wdata, stk_rdata;
    logic            fin_we;
    logic [AW-1:0]   fin_waddr, fin_raddr;
    logic [VW-1:0]   fin_wdata, fin_rdata;

    dts_ram #(.Width(N), .Depth(N)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata));
    dts_ram #(.Width(2*VW), .Depth(N)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata));
    dts_ram #(.Width(VW), .Depth(N)) u_fin (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(fin_wdata),
        .i_raddr(fin_raddr), .o_rdata(fin_rdata));

    logic [VW-1:0] eff_n;
    assign eff_n = (r_count > VW'(N)) ? VW'(N) : r_count;

    // vertex v maps to ram row v-1
    function automatic logic [AW-1:0] f_row(input logic [VW-1:0] v);
        logic [VW-1:0] t;
        t = v - VW'(1);
        return t[AW-1:0];
    endfunction

    // first set neighbor w >= r_top_next, w <= r_n; w is bit w-1 of the row
    logic [VW-1:0] nb_w;
    logic          nb_found;
    always_comb begin
        nb_w = '0;
        nb_found = 1'b0;
        for (int j = N; j >= 1; j--) begin
            if (adj_rdata[j-1] && VW'(j) >= r_top_next && VW'(j) <= r_n) begin
                nb_w = VW'(j);
                nb_found = 1'b1;
            end
        end
    end

    logic [1:0] nb_col;
    assign nb_col = r_col[f_row(nb_w)];

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_kind  = r_okind;
    assign o_value = r_ovalue;
    assign o_last  = r_olast;

    logic accept;
    assign accept = i_valid && o_ready;
    logic out_free;
    assign out_free = !r_ovalid || i_ready;

    // a new result enters the output register this cycle
    logic out_load;
    assign out_load = out_free && ((r_state == S_STAT) || (r_state == S_OUT) ||
                      (r_state == S_STEP && nb_found && nb_col == dts_pkg::COL_GRAY));

    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = r_efrom;
        adj_wdata = adj_rdata | (N'(1) << (r_eto - VW'(1)));
        adj_raddr = f_row(r_top_v);
        stk_we    = 1'b0;
        stk_waddr = r_depth[AW-1:0];
        stk_wdata = {r_top_v, r_top_next};
        stk_raddr = f_row(r_depth - VW'(1));
        fin_we    = 1'b0;
        fin_waddr = r_fin[AW-1:0];
        fin_wdata = r_top_v;
        fin_raddr = f_row(r_fin);
        unique case (r_state)
            S_CLEAR: begin
                adj_we = 1'b1; adj_waddr = r_clr; adj_wdata = '0;
            end
            S_IDLE: adj_raddr = f_row(i_edge_from);
            S_ADD:  adj_we = 1'b1;
            S_STEP: begin
                if (nb_found && nb_col == dts_pkg::COL_WHITE) begin
                    // save current top with advanced pointer before push
                    stk_we = 1'b1;
                    stk_waddr = f_row(r_depth);
                    stk_wdata = {r_top_v, nb_w + VW'(1)};
                end else if (!nb_found) begin
                    fin_we = 1'b1;
                    stk_raddr = f_row(r_depth - VW'(1));
                end
            end
            // read ahead the entry for the count after this result
            S_OUT: if (out_free) fin_raddr = f_row(r_fin - VW'(1));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= VW'(N);
            r_ovalid <= 1'b0;
            r_depth  <= '0;
            r_fin    <= '0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_wdata;
            if (out_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(N - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (accept) begin
                    r_efrom <= f_row(i_edge_from);
                    r_eto   <= i_edge_to;
                    unique case (dts_pkg::t_action'(i_action))
                        dts_pkg::ACT_ADD:
                            if (i_edge_from >= VW'(1) && i_edge_from <= eff_n &&
                                i_edge_to >= VW'(1) && i_edge_to <= eff_n)
                                r_state <= S_ADD;
                        dts_pkg::ACT_RUN: begin
                            r_n     <= eff_n;
                            r_root  <= VW'(1);
                            r_depth <= '0;
                            r_fin   <= '0;
                            for (int k = 0; k < N; k++) r_col[k] <= dts_pkg::COL_WHITE;
                            r_state <= S_ROOT;
                        end
                        dts_pkg::ACT_CLEAR: begin
                            r_clr <= '0;
                            r_state <= S_CLEAR;
                        end
                        default: ;
                    endcase
                end
                S_ADD: r_state <= S_IDLE;
                S_ROOT: begin
                    if (r_root > r_n) begin
                        r_state <= S_STAT;
                    end else if (r_col[f_row(r_root)] == dts_pkg::COL_WHITE) begin
                        r_col[f_row(r_root)] <= dts_pkg::COL_GRAY;
                        r_top_v    <= r_root;
                        r_top_next <= VW'(1);
                        r_depth    <= VW'(1);
                        r_state    <= S_READ;
                    end
                    r_root <= r_root + VW'(1);
                end
                S_READ: r_state <= S_STEP;
                S_STEP: begin
                    if (nb_found) begin
                        if (nb_col == dts_pkg::COL_GRAY) begin
                            // cycle: status 0 only
                            if (out_free) begin
                                r_okind  <= 1'b0;
                                r_ovalue <= '0;
                                r_olast  <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end else if (nb_col == dts_pkg::COL_WHITE) begin
                            r_col[f_row(nb_w)] <= dts_pkg::COL_GRAY;
                            r_top_v    <= nb_w;
                            r_top_next <= VW'(1);
                            r_depth    <= r_depth + VW'(1);
                            r_state    <= S_READ;
                        end else begin
                            r_top_next <= nb_w + VW'(1);
                            r_state    <= S_READ;
                        end
                    end else begin
                        r_col[f_row(r_top_v)] <= dts_pkg::COL_BLACK;
                        r_fin   <= r_fin + VW'(1);
                        r_depth <= r_depth - VW'(1);
                        // popped entry data arrives next cycle
                        r_state <= (r_depth == VW'(1)) ? S_ROOT : S_OUTRD;
                    end
                end
                S_OUTRD: begin
                    // stack pop: stack ram holds parent with saved pointer
                    r_top_v    <= stk_rdata[2*VW-1:VW];
                    r_top_next <= stk_rdata[VW-1:0];
                    r_state    <= S_READ;
                end
                S_STAT: if (out_free) begin
                    r_okind  <= 1'b0;
                    r_ovalue <= VW'(1);
                    r_olast  <= (r_fin == '0);
                    r_state  <= (r_fin == '0) ? S_IDLE : S_OUT;
                end
                S_OUT: if (out_free) begin
                    // fin_rdata holds the entry at r_fin-1
                    r_okind  <= 1'b1;
                    r_ovalue <= fin_rdata;
                    r_olast  <= (r_fin == VW'(1));
                    r_fin    <= r_fin - VW'(1);
                    if (r_fin == VW'(1)) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= VW'(N)) else $error("stack overflow");
    a_fin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin <= VW'(N)) else $error("finish list overflow");
`endif
endmodule
